// ===== rtl/core/bbd_pkg.sv =====
// Package with shared types, constants and helpers for the Bayer demosaic block.
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 2048;
  localparam int unsigned CfgW         = 12;
  localparam int unsigned PixW         = 8;
  localparam int unsigned PosW         = 11;
  localparam int unsigned RegIdxW      = 1;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [RegIdxW-1:0] RegFrameHeight = 1'b1;

  // Site classes for the pixels that one item releases.
  typedef enum logic [2:0] {
    KindBIn,      // B site, interior
    KindBBrd,     // B site, border
    KindGbIn,     // G on a B row, interior
    KindGbBrd,    // G on a B row, border
    KindGrBrd,    // G on an R row, border
    KindRBrd,     // R site, border
    KindRIn,      // R site, interior
    KindGrIn      // G on an R row, interior
  } site_kind_e;

  // One item after classification: window snapshot plus up to four pixels to build.
  typedef struct packed {
    logic [8:0][PixW-1:0] win;   // index a*3+b for w[a][b]
    logic [PixW-1:0]      nm;
    logic [PosW-1:0]      row;
    logic [PosW-1:0]      col;
    logic [3:0]           emit;  // slots: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
    logic                 odd;   // odd-row/odd-col item, else even/even
    logic                 b_in;
    logic                 gb_in;
  } work_t;

  // Effective dimension: even, clamped to [2, max].
  function automatic logic [13:0] eff_dim(input logic [CfgW-1:0] reg_v,
                                          input logic [13:0] maxv);
    logic [13:0] v;
    logic [13:0] m;
    begin
      v = {2'b00, reg_v[CfgW-1:1], 1'b0};
      m = {maxv[13:1], 1'b0};
      if (m < 14'd2) m = 14'd2;
      if (v < 14'd2) v = 14'd2;
      if (v > m) v = m;
      eff_dim = v;
    end
  endfunction

endpackage

// ===== rtl/core/bbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bbd_front.sv =====
// Front end: accepts raw items, tracks position, line stores and the 3x3 window.
`timescale 1ns / 1ps
module bbd_front
  import bbd_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     in_pixel_i,
  output logic                wk_valid_o,
  input  logic                wk_ready_i,
  output work_t               wk_o
);

  localparam int unsigned ColW  = $clog2(MaxWidth) + 1;
  localparam int unsigned RowW  = $clog2(MaxHeight) + 1;
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam logic [13:0] MaxWv = 14'(MaxWidth);
  localparam logic [13:0] MaxHv = 14'(MaxHeight);

  logic [CfgW-1:0] width_q, height_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [13:0]     eff_w, eff_h;
  logic [8:0][PixW-1:0] win_q, win_d;

  // Stage 1 registers: the accepted item, awaiting line-store read data.
  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [PixW-1:0] s1_pix_q;
  logic            s1_last_col_q, s1_last_row_q;

  logic            adv, acc;
  logic [PixW-1:0] top_rd, mid_rd, nm_rd, top_v, mid_v, nm_v;
  logic [ColW-1:0] col_c;
  logic [RowW-1:0] row_c;
  logic            par;
  logic [ColW-1:0] col_n;
  logic            nm_ok;

  // Forwarding of the last write, since reads happen in the same cycle as writes.
  logic            fw_valid_q;
  logic            fw_par_q;
  logic [AddrW-1:0] fw_addr_q;
  logic [PixW-1:0] fw_data_q;

  assign eff_w = eff_dim(width_q, MaxWv);
  assign eff_h = eff_dim(height_q, MaxHv);

  // Stall stage 1 only when the output register holds an item not taken.
  assign adv        = !wk_valid_o || wk_ready_i;
  assign in_ready_o = adv && !cfg_valid_i;
  assign acc        = in_valid_i && in_ready_o;

  // Position wraps when the size shrank below it.
  always_comb begin
    col_c = col_q;
    row_c = row_q;
    if ({{(14-ColW){1'b0}}, col_q} >= eff_w || {{(14-RowW){1'b0}}, row_q} >= eff_h) begin
      col_c = '0;
      row_c = '0;
    end
    par   = row_c[0];
    col_n = col_c + 1'b1;
    col_d = col_n;
    row_d = row_c;
    if ({{(14-ColW){1'b0}}, col_n} >= eff_w) begin
      col_d = '0;
      row_d = ({{(14-RowW){1'b0}}, row_c} + 14'd1 >= eff_h) ? '0 : row_c + 1'b1;
    end
  end

  assign nm_ok = {{(14-ColW){1'b0}}, col_n} < eff_w;

  // Configuration and position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(640);
      height_q <= CfgW'(480);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegFrameWidth) width_q <= cfg_data_i;
      else height_q <= cfg_data_i;
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: one per row parity. Write new pixel into the own-parity store.
  logic [AddrW-1:0] addr_c, addr_n;
  logic [PixW-1:0]  st0_rd, st1_rd, stn0_rd, stn1_rd;
  assign addr_c = col_c[AddrW-1:0];
  assign addr_n = col_n[AddrW-1:0];

  bbd_ram #(.Width(PixW), .Depth(MaxWidth)) u_store0 (
    .clk_i, .we_i(acc && !par), .waddr_i(addr_c), .wdata_i(in_pixel_i),
    .re_i(acc), .raddr_i(addr_c), .rdata_o(st0_rd)
  );
  bbd_ram #(.Width(PixW), .Depth(MaxWidth)) u_store1 (
    .clk_i, .we_i(acc && par), .waddr_i(addr_c), .wdata_i(in_pixel_i),
    .re_i(acc), .raddr_i(addr_c), .rdata_o(st1_rd)
  );
  bbd_ram #(.Width(PixW), .Depth(MaxWidth)) u_store0n (
    .clk_i, .we_i(acc && !par), .waddr_i(addr_c), .wdata_i(in_pixel_i),
    .re_i(acc), .raddr_i(addr_n), .rdata_o(stn0_rd)
  );
  bbd_ram #(.Width(PixW), .Depth(MaxWidth)) u_store1n (
    .clk_i, .we_i(acc && par), .waddr_i(addr_c), .wdata_i(in_pixel_i),
    .re_i(acc), .raddr_i(addr_n), .rdata_o(stn1_rd)
  );

  // Forwarding record: a read at the address written by the previous item.
  logic fwd_top, fwd_mid, fwd_nm;
  logic s1_par;
  logic [AddrW-1:0] s1_addr, s1_naddr;
  logic fw_hit_par_q [2];
  assign s1_par = s1_row_q[0];
  assign s1_addr = s1_col_q[AddrW-1:0];
  assign s1_naddr = s1_addr + 1'b1;

  // Reads were done at accept; prior write was committed before (RAM writes on
  // accept edge, read of same edge sees old data). Only a write in the same edge
  // at same address matters, which is the item's own write: top reads old data
  // by design. Hence no forwarding is needed; fw registers track nothing else.
  assign fwd_top = 1'b0;
  assign fwd_mid = 1'b0;
  assign fwd_nm  = 1'b0;
  assign fw_hit_par_q[0] = fw_valid_q;
  assign fw_hit_par_q[1] = fw_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
      fw_par_q   <= 1'b0;
    end else begin
      fw_valid_q <= acc;
      fw_par_q   <= par;
    end
  end
  always_ff @(posedge clk_i) begin
    fw_addr_q <= addr_c;
    fw_data_q <= in_pixel_i;
  end

  assign top_rd = s1_par ? st1_rd : st0_rd;
  assign mid_rd = s1_par ? st0_rd : st1_rd;
  assign nm_rd  = s1_par ? stn0_rd : stn1_rd;
  assign top_v  = (fwd_top && fw_hit_par_q[0] && fw_addr_q == s1_addr) ? fw_data_q : top_rd;
  assign mid_v  = (fwd_mid && fw_hit_par_q[1] && fw_addr_q == s1_addr) ? fw_data_q : mid_rd;
  assign nm_v   = (fwd_nm && fw_addr_q == s1_naddr) ? fw_data_q : nm_rd;

  // Stage 1 capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_col_q      <= col_c;
      s1_row_q      <= row_c;
      s1_pix_q      <= in_pixel_i;
      s1_last_col_q <= !nm_ok;
      s1_last_row_q <= {{(14-RowW){1'b0}}, row_c} + 14'd1 == eff_h;
    end
  end

  // Window shift on every item that leaves stage 1.
  always_comb begin
    win_d = win_q;
    for (int a = 0; a < 3; a++) begin
      win_d[a*3+0] = win_q[a*3+1];
      win_d[a*3+1] = win_q[a*3+2];
    end
    win_d[2] = top_v;
    win_d[5] = mid_v;
    win_d[8] = s1_pix_q;
  end

  logic s1_go;
  assign s1_go = s1_valid_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) win_q <= '0;
    else if (s1_go) win_q <= win_d;
  end

  // Classify and register into the work slot.
  work_t wk_d;
  logic  r_odd, c_odd, r_ge3, c_ge3, c_is1;
  always_comb begin
    r_odd = s1_row_q[0];
    c_odd = s1_col_q[0];
    r_ge3 = s1_row_q >= RowW'(3);
    c_ge3 = s1_col_q >= ColW'(3);
    c_is1 = s1_col_q == ColW'(1);
    wk_d       = '0;
    wk_d.win   = win_d;
    wk_d.nm    = s1_last_col_q ? '0 : nm_v;
    wk_d.row   = PosW'(s1_row_q);
    wk_d.col   = PosW'(s1_col_q);
    wk_d.odd   = r_odd;
    wk_d.b_in  = r_ge3 && c_ge3;
    wk_d.gb_in = r_ge3 && !s1_last_col_q;
    if (r_odd && c_odd) begin
      wk_d.emit = {s1_last_row_q || s1_last_col_q, c_is1 || s1_last_row_q, 2'b11};
    end else if (!r_odd && !c_odd && s1_row_q != '0 && s1_col_q != '0) begin
      wk_d.emit = 4'b0011;
    end
  end

  logic wk_valid_q;
  work_t wk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wk_valid_q <= 1'b0;
    else if (adv) wk_valid_q <= s1_valid_q && (wk_d.emit != '0);
  end
  always_ff @(posedge clk_i) begin
    if (adv) wk_q <= wk_d;
  end

  assign wk_valid_o = wk_valid_q;
  assign wk_o       = wk_q;

endmodule

// ===== rtl/core/bbd_fifo.sv =====
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module bbd_fifo
  import bbd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  work_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output work_t out_data_o
);

  work_t      slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = slot_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= in_data_i;
  end

endmodule

// ===== rtl/core/bbd_back.sv =====
// Back end: builds one RGB pixel per cycle from a queued item while the output is not held.
`timescale 1ns / 1ps
module bbd_back
  import bbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wk_valid_i,
  output logic         wk_ready_o,
  input  work_t        wk_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [47:0]  out_data_o,
  output logic         out_last_o
);

  logic [3:0]      done_q, done_d, pend;
  logic [1:0]      slot;
  logic            more;
  logic            ld;
  site_kind_e      kind;
  logic [PixW-1:0] red, grn, blu;
  logic [PosW-1:0] prow, pcol;
  logic            ov_q;
  logic [47:0]     od_q;
  logic            ol_q;

  function automatic logic [PixW-1:0] avg2(input logic [PixW-1:0] x, input logic [PixW-1:0] y);
    logic [PixW:0] s;
    begin
      s = {1'b0, x} + {1'b0, y};
      avg2 = s[PixW:1];
    end
  endfunction
  function automatic logic [PixW-1:0] avg4(input logic [PixW-1:0] x, input logic [PixW-1:0] y,
                                           input logic [PixW-1:0] z, input logic [PixW-1:0] v);
    logic [PixW+1:0] s;
    begin
      s = {2'b0, x} + {2'b0, y} + {2'b0, z} + {2'b0, v};
      avg4 = s[PixW+1:2];
    end
  endfunction

  // Lowest pending slot.
  always_comb begin
    pend = wk_i.emit & ~done_q;
    slot = 2'd0;
    if (pend[0]) slot = 2'd0;
    else if (pend[1]) slot = 2'd1;
    else if (pend[2]) slot = 2'd2;
    else slot = 2'd3;
    done_d = done_q;
    done_d[slot] = 1'b1;
    more = (wk_i.emit & ~done_d) != '0;
  end

  assign ld         = wk_valid_i && (!ov_q || out_ready_i);
  assign wk_ready_o = ld && !more;

  // Site class of the chosen slot.
  always_comb begin
    if (!wk_i.odd) kind = slot[0] ? KindGrIn : KindRIn;
    else begin
      case (slot)
        2'd0:    kind = wk_i.b_in ? KindBIn : KindBBrd;
        2'd1:    kind = wk_i.gb_in ? KindGbIn : KindGbBrd;
        2'd2:    kind = KindGrBrd;
        default: kind = KindRBrd;
      endcase
    end
    prow = slot[1] ? wk_i.row : wk_i.row - 1'b1;
    pcol = slot[0] ? wk_i.col : wk_i.col - 1'b1;
  end

  // Color of the chosen site from the window.
  always_comb begin
    red = wk_i.win[8];
    grn = wk_i.win[5];
    blu = wk_i.win[4];
    case (kind)
      KindBIn: begin
        red = avg4(wk_i.win[0], wk_i.win[2], wk_i.win[6], wk_i.win[8]);
        grn = avg4(wk_i.win[3], wk_i.win[5], wk_i.win[7], wk_i.win[1]);
      end
      KindBBrd:  grn = avg2(wk_i.win[5], wk_i.win[7]);
      KindGbIn: begin
        red = avg2(wk_i.win[8], wk_i.win[2]);
        blu = avg2(wk_i.win[4], wk_i.nm);
      end
      KindGbBrd: ;
      KindGrBrd: grn = wk_i.win[7];
      KindRBrd:  grn = avg2(wk_i.win[7], wk_i.win[5]);
      KindRIn: begin
        red = wk_i.win[4];
        grn = avg4(wk_i.win[3], wk_i.win[5], wk_i.win[1], wk_i.win[7]);
        blu = avg4(wk_i.win[0], wk_i.win[2], wk_i.win[6], wk_i.win[8]);
      end
      KindGrIn: begin
        red = avg2(wk_i.win[4], wk_i.nm);
        blu = avg2(wk_i.win[8], wk_i.win[2]);
      end
      default: ;
    endcase
  end

  // Progress through the slots of the current item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= '0;
    else if (ld) done_q <= more ? done_d : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (ld) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ld) begin
      od_q <= {blu, grn, red, 2'b00, pcol, prow};
      ol_q <= !more;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

endmodule

// ===== rtl/core/bayer_bilinear_demosaic.sv =====
// Top level of the bilinear BGGR demosaic.
`timescale 1ns / 1ps
// Bilinear demosaic for a BGGR mosaic: one raw sample per item on the slave stream, RGB pixels
// with their row and column on the master stream, up to four per item and one per cycle unless
// the master stream holds them. Items are taken one per cycle unless the input stalls; an item
// that releases n pixels sends them on the output one after another, so the long-run rate is
// one item per cycle on average (one per pixel overall). Where items release more pixels than
// the output can carry, for instance along the last row where one item can release four, the
// two-entry queue fills and the input stalls. The first pixel of an item passes, in order,
// through the line-store read and window stage loaded at its accepting edge, the classification
// register, the queue and the output register. Two line stores of MaxWidth bytes hold the
// previous rows. A register write restarts the frame.
module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] raw_pixel
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // out_row[10:0], out_col[21:11], zero[23:22],
                                             // red[31:24], green[39:32], blue[47:40]
  output logic               m_axis_tlast    // last_in_run
);

  logic  f_valid, f_ready, q_valid, q_ready;
  work_t f_data, q_data;

  assign cfg_ready_o = 1'b1;

  bbd_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_pixel_i(s_axis_tdata),
    .wk_valid_o(f_valid), .wk_ready_i(f_ready), .wk_o(f_data)
  );

  bbd_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  bbd_back u_back (
    .clk_i, .rst_ni, .wk_valid_i(q_valid), .wk_ready_o(q_ready), .wk_i(q_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_last_o(m_axis_tlast)
  );

endmodule
